FILE: rtl/sas_pkg.sv
// Shared types and constants of the servo arm sequencer.
`default_nettype none

package sas_pkg;

    // Arm phase codes.
    localparam logic [2:0] PH_STOWED_IDLE   = 3'd0;
    localparam logic [2:0] PH_STOWED        = 3'd1;
    localparam logic [2:0] PH_DOOR_OPEN     = 3'd2;
    localparam logic [2:0] PH_EXTENDED      = 3'd3;
    localparam logic [2:0] PH_THUMB_UP      = 3'd4;
    localparam logic [2:0] PH_THUMB_UP_IDLE = 3'd5;

    // Servo pulse widths in microseconds.
    localparam logic [10:0] DOOR_OPEN_US    = 11'd1800;
    localparam logic [10:0] DOOR_CLOSED_US  = 11'd1000;
    localparam logic [10:0] EXTEND_IN_US    = 11'd1900;
    localparam logic [10:0] EXTEND_OUT_US   = 11'd1080;
    localparam logic [10:0] LIGHTER_DOWN_US = 11'd2000;
    localparam logic [10:0] LIGHTER_UP_US   = 11'd940;
    localparam logic [10:0] PULSE_OFF_US    = 11'd0;
    localparam logic [11:0] HEAD_CENTRE_US  = 12'd1500;

    // Step waits in millisecond ticks.
    localparam int WAIT_W = 9;
    localparam logic [WAIT_W-1:0] WAIT_NONE  = 9'd0;
    localparam logic [WAIT_W-1:0] WAIT_SHORT = 9'd200;
    localparam logic [WAIT_W-1:0] WAIT_MID   = 9'd300;
    localparam logic [WAIT_W-1:0] WAIT_LONG  = 9'd400;

    // Configuration register indexes.
    localparam logic [2:0] REG_MASK_A    = 3'd0;
    localparam logic [2:0] REG_MASK_B    = 3'd1;
    localparam logic [2:0] REG_MASK_X    = 3'd2;
    localparam logic [2:0] REG_MASK_Y    = 3'd3;
    localparam logic [2:0] REG_DEAD_BAND = 3'd4;

    // Controller side codes.
    localparam logic [1:0] SIDE_LEFT  = 2'd1;
    localparam logic [1:0] SIDE_RIGHT = 2'd2;

    // Configuration as seen by the controller decode.
    typedef struct packed {
        logic [15:0] mask_a;
        logic [15:0] mask_b;
        logic [15:0] mask_x;
        logic [15:0] mask_y;
        logic [8:0]  dead_band;
    } cfg_t;

    // Arm actuator state moved by one sequence step.
    typedef struct packed {
        logic [2:0]  phase;
        logic [10:0] door;
        logic [10:0] extend;
        logic [10:0] lighter;
        logic        flame;
    } arm_state_t;

    // Outcome of decoding one controller update.
    typedef struct packed {
        logic        arm_edge;
        logic        sound_edge;
        logic [10:0] head_pulse;
    } ctrl_result_t;

endpackage

`default_nettype wire

FILE: rtl/sas_step.sv
// One step of the extend or retract sequence of the arm.
`default_nettype none

module sas_step (
    input  sas_pkg::arm_state_t              cur,
    input  logic                             retract,
    output sas_pkg::arm_state_t              nxt,
    output logic [sas_pkg::WAIT_W-1:0]       wait_ticks,
    output logic                             clip
);

    // Pick the next actuator settings from the phase and direction.
    always_comb begin
        nxt        = cur;
        wait_ticks = sas_pkg::WAIT_NONE;
        clip       = 1'b0;
        if (!retract) begin
            case (cur.phase)
                sas_pkg::PH_STOWED_IDLE, sas_pkg::PH_STOWED: begin
                    nxt.door   = sas_pkg::DOOR_OPEN_US;
                    nxt.phase  = sas_pkg::PH_DOOR_OPEN;
                    wait_ticks = sas_pkg::WAIT_MID;
                end
                sas_pkg::PH_DOOR_OPEN: begin
                    clip       = 1'b1;
                    nxt.extend = sas_pkg::EXTEND_OUT_US;
                    nxt.phase  = sas_pkg::PH_EXTENDED;
                    wait_ticks = sas_pkg::WAIT_LONG;
                end
                sas_pkg::PH_EXTENDED: begin
                    nxt.lighter = sas_pkg::LIGHTER_UP_US;
                    nxt.flame   = 1'b1;
                    nxt.phase   = sas_pkg::PH_THUMB_UP;
                    wait_ticks  = sas_pkg::WAIT_MID;
                end
                sas_pkg::PH_THUMB_UP: begin
                    nxt.lighter = sas_pkg::PULSE_OFF_US;
                    nxt.phase   = sas_pkg::PH_THUMB_UP_IDLE;
                end
                default: begin
                    nxt = cur;
                end
            endcase
        end else begin
            case (cur.phase)
                sas_pkg::PH_THUMB_UP_IDLE, sas_pkg::PH_THUMB_UP: begin
                    nxt.lighter = sas_pkg::LIGHTER_DOWN_US;
                    nxt.flame   = 1'b0;
                    nxt.phase   = sas_pkg::PH_EXTENDED;
                    wait_ticks  = sas_pkg::WAIT_SHORT;
                end
                sas_pkg::PH_EXTENDED: begin
                    nxt.extend = sas_pkg::EXTEND_IN_US;
                    nxt.phase  = sas_pkg::PH_DOOR_OPEN;
                    wait_ticks = sas_pkg::WAIT_MID;
                end
                sas_pkg::PH_DOOR_OPEN: begin
                    nxt.door   = sas_pkg::DOOR_CLOSED_US;
                    nxt.phase  = sas_pkg::PH_STOWED;
                    wait_ticks = sas_pkg::WAIT_MID;
                end
                sas_pkg::PH_STOWED: begin
                    nxt.door    = sas_pkg::PULSE_OFF_US;
                    nxt.lighter = sas_pkg::PULSE_OFF_US;
                    nxt.phase   = sas_pkg::PH_STOWED_IDLE;
                end
                default: begin
                    nxt = cur;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sas_ctrl.sv
// Controller update decode: button mapping, edge detection and head servo pulse.
`default_nettype none

module sas_ctrl (
    input  sas_pkg::cfg_t          cfg,
    input  logic [15:0]            buttons,
    input  logic [15:0]            last_buttons,
    input  logic [1:0]             side,
    input  logic signed [9:0]      axis_x,
    input  logic signed [9:0]      axis_y,
    output sas_pkg::ctrl_result_t  res
);

    logic [15:0]        arm_mask;
    logic [15:0]        snd_mask;
    logic signed [10:0] axis;
    logic signed [10:0] db;
    logic signed [10:0] axis_adj;
    logic signed [11:0] pulse;

    // Map buttons and axis by controller side.
    always_comb begin
        case (side)
            sas_pkg::SIDE_LEFT: begin
                arm_mask = cfg.mask_x;
                snd_mask = cfg.mask_b;
                axis     = 11'(axis_y);
            end
            sas_pkg::SIDE_RIGHT: begin
                arm_mask = cfg.mask_b;
                snd_mask = cfg.mask_x;
                axis     = -11'(axis_y);
            end
            default: begin
                arm_mask = cfg.mask_y;
                snd_mask = cfg.mask_a;
                axis     = -11'(axis_x);
            end
        endcase
    end

    // A rising edge is a mask pressed now that had no bit set before.
    assign res.arm_edge   = (|(buttons & arm_mask)) && !(|(last_buttons & arm_mask));
    assign res.sound_edge = (|(buttons & snd_mask)) && !(|(last_buttons & snd_mask));

    // Deadzone pulls the axis toward zero by the dead band.
    assign db = $signed({2'b00, cfg.dead_band});

    always_comb begin
        if (axis > db) begin
            axis_adj = axis - db;
        end else if (axis < -db) begin
            axis_adj = axis + db;
        end else begin
            axis_adj = '0;
        end
    end

    assign pulse          = $signed(sas_pkg::HEAD_CENTRE_US) + 12'(axis_adj);
    assign res.head_pulse = pulse[10:0];

endmodule

`default_nettype wire

FILE: rtl/servo_arm_sequencer_core.sv
// Top level of the servo arm sequencer: state, configuration and result register.
//
// The input channel (s_*) takes one item per cycle while s_ready is high:
// either a controller update (s_operation = 0) or a one millisecond tick
// (s_operation = 1). Every accepted item gives exactly one result item on the
// m_* channel in the next cycle, from a single result register. The sequencer
// state is updated at the edge that accepts the item, so items may follow back
// to back: one item per cycle is sustained while the receiver takes results,
// with the single step decode between the state and the result register.
// When the receiver stalls, the result register holds its item and s_ready
// falls; s_ready is high whenever the result register is empty or is being
// emptied in the same cycle, so no bubble is added.
// Reset (aresetn low, synchronous) empties the result register, restores the
// configuration defaults and puts the arm in the thumb up phase with a retract
// step due, so the first tick starts the retract sequence. Configuration is
// written through cfg_wr_en, cfg_index and cfg_wdata; the block relies on the
// user to write it only while the block is idle. Other indexes are ignored.
`default_nettype none

module servo_arm_sequencer_core (
    input  logic               aclk,
    input  logic               aresetn,
    // Configuration write port
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    // Input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_operation,
    input  logic [15:0]        s_buttons,
    input  logic [1:0]         s_side,
    input  logic signed [9:0]  s_axis_x,
    input  logic signed [9:0]  s_axis_y,
    // Result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [10:0]        m_head_pulse_us,
    output logic [10:0]        m_door_pulse_us,
    output logic [10:0]        m_extend_pulse_us,
    output logic [10:0]        m_lighter_pulse_us,
    output logic               m_flame_on,
    output logic               m_clip_request,
    output logic               m_random_sound_request,
    output logic [2:0]         m_arm_phase
);

    sas_pkg::cfg_t                cfg_reg;
    sas_pkg::arm_state_t          arm_reg;
    sas_pkg::arm_state_t          arm_next;
    sas_pkg::arm_state_t          step_state;
    sas_pkg::ctrl_result_t        ctrl;
    logic                         retract_reg;
    logic                         retract_next;
    logic                         pending_reg;
    logic                         pending_next;
    logic [sas_pkg::WAIT_W-1:0]   wait_reg;
    logic [sas_pkg::WAIT_W-1:0]   wait_next;
    logic [sas_pkg::WAIT_W-1:0]   wait_dec;
    logic [sas_pkg::WAIT_W-1:0]   step_wait;
    logic [15:0]                  last_buttons_reg;
    logic [10:0]                  head_pulse_reg;
    logic [10:0]                  head_next;
    logic                         step_clip;
    logic                         do_step;
    logic                         step_retract;
    logic                         at_idle;
    logic                         accept;

    assign s_ready = !m_valid || m_ready;
    assign accept  = s_valid && s_ready;

    // Controller decode and step logic.
    sas_ctrl u_ctrl (
        .cfg          (cfg_reg),
        .buttons      (s_buttons),
        .last_buttons (last_buttons_reg),
        .side         (s_side),
        .axis_x       (s_axis_x),
        .axis_y       (s_axis_y),
        .res          (ctrl)
    );

    sas_step u_step (
        .cur        (arm_reg),
        .retract    (step_retract),
        .nxt        (step_state),
        .wait_ticks (step_wait),
        .clip       (step_clip)
    );

    // Decide whether a step runs for this item and which way it goes.
    assign at_idle  = (arm_reg.phase == sas_pkg::PH_STOWED_IDLE) ||
                      (arm_reg.phase == sas_pkg::PH_THUMB_UP_IDLE);
    assign wait_dec = (wait_reg != '0) ? wait_reg - 1'b1 : wait_reg;

    always_comb begin
        if (s_operation) begin
            do_step      = pending_reg && (wait_dec == '0);
            step_retract = retract_reg;
        end else begin
            do_step      = ctrl.arm_edge && at_idle;
            step_retract = (arm_reg.phase == sas_pkg::PH_THUMB_UP_IDLE);
        end
    end

    // Next sequencer state.
    always_comb begin
        arm_next     = arm_reg;
        retract_next = retract_reg;
        pending_next = pending_reg;
        wait_next    = wait_reg;
        head_next    = s_operation ? head_pulse_reg : ctrl.head_pulse;
        if (do_step) begin
            arm_next     = step_state;
            retract_next = step_retract;
            wait_next    = step_wait;
            pending_next = (step_wait != '0);
        end else if (s_operation && pending_reg) begin
            wait_next = wait_dec;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mask_a    <= 16'd1;
            cfg_reg.mask_b    <= 16'd2;
            cfg_reg.mask_x    <= 16'd4;
            cfg_reg.mask_y    <= 16'd8;
            cfg_reg.dead_band <= 9'd100;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                sas_pkg::REG_MASK_A:    cfg_reg.mask_a    <= cfg_wdata;
                sas_pkg::REG_MASK_B:    cfg_reg.mask_b    <= cfg_wdata;
                sas_pkg::REG_MASK_X:    cfg_reg.mask_x    <= cfg_wdata;
                sas_pkg::REG_MASK_Y:    cfg_reg.mask_y    <= cfg_wdata;
                sas_pkg::REG_DEAD_BAND: cfg_reg.dead_band <= cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    // Sequencer state, updated on each accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arm_reg.phase    <= sas_pkg::PH_THUMB_UP;
            arm_reg.door     <= sas_pkg::PULSE_OFF_US;
            arm_reg.extend   <= sas_pkg::PULSE_OFF_US;
            arm_reg.lighter  <= sas_pkg::PULSE_OFF_US;
            arm_reg.flame    <= 1'b0;
            retract_reg      <= 1'b1;
            pending_reg      <= 1'b1;
            wait_reg         <= '0;
            last_buttons_reg <= '0;
            head_pulse_reg   <= sas_pkg::PULSE_OFF_US;
        end else if (accept) begin
            arm_reg        <= arm_next;
            retract_reg    <= retract_next;
            pending_reg    <= pending_next;
            wait_reg       <= wait_next;
            head_pulse_reg <= head_next;
            if (!s_operation) begin
                last_buttons_reg <= s_buttons;
            end
        end
    end

    // Result register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (accept) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    // Result payload, loaded with the state that the item leaves behind.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_head_pulse_us        <= head_next;
            m_door_pulse_us        <= arm_next.door;
            m_extend_pulse_us      <= arm_next.extend;
            m_lighter_pulse_us     <= arm_next.lighter;
            m_flame_on             <= arm_next.flame;
            m_clip_request         <= do_step && step_clip;
            m_random_sound_request <= !s_operation && ctrl.sound_edge;
            m_arm_phase            <= arm_next.phase;
        end
    end

    // A clip is only requested by the step that extends the arm.
    a_clip_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_clip_request |-> m_arm_phase == sas_pkg::PH_EXTENDED)
        else $error("clip request outside the extended phase");

    // No wait is left running once no step is pending.
    a_wait_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !pending_reg |-> wait_reg == '0)
        else $error("wait count running with no step pending");

    // Reaching the stowed idle phase releases the door and lighter servos.
    a_stowed_released: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_arm_phase == sas_pkg::PH_STOWED_IDLE |->
            m_door_pulse_us == sas_pkg::PULSE_OFF_US &&
            m_lighter_pulse_us == sas_pkg::PULSE_OFF_US)
        else $error("stowed idle with a servo still driven");

    // A tick leaves the head servo pulse unchanged.
    a_tick_head: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_operation |=> m_head_pulse_us == $past(head_pulse_reg))
        else $error("tick changed the head servo pulse");

endmodule

`default_nettype wire
